FILE: sv/urc_pkg.sv
// Shared types and constants for the ultrasonic ranger controller.
// No dependencies; every other file in sv/ refers to this package by scoped names.
`default_nettype none

package urc_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND_SPEED   = 2'd2;

  localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd20;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'hFFFF;
  localparam logic [9:0]  SOUND_SPEED_RST   = 10'd343;

  // Status codes shown on the result channel
  localparam logic [1:0] STATUS_IDLE    = 2'd0;
  localparam logic [1:0] STATUS_TRIG    = 2'd1;
  localparam logic [1:0] STATUS_MEASURE = 2'd2;
  localparam logic [1:0] STATUS_FAULT   = 2'd3;

  // Largest distance that the width and speed ranges can produce
  localparam logic [14:0] DISTANCE_MAX = 15'd16759;

  // Distance arithmetic: prod = (width >> 2) * speed fits 24 bits;
  // prod / 1000 == (prod * RECIP_MUL) >> RECIP_SHIFT exactly for prod < 2^24.
  localparam int unsigned PROD_W      = 24;
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned RECIP_SHIFT = 34;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 25'd17179870;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TRIG  = 3'd1,
    PH_WAIT  = 3'd2,
    PH_FAULT = 3'd3,
    PH_HIGH  = 3'd4
  } phase_e;

  typedef struct packed {
    logic echo_level;
    logic start_req;
  } in_t;

  typedef struct packed {
    logic        trigger_level;
    logic [1:0]  status;
    logic        done_res;
    logic [15:0] echo_width;
    logic [14:0] distance_mm;
  } out_t;

  // Result fields known right after the state update
  typedef struct packed {
    logic        trigger_level;
    logic [1:0]  status;
    logic        done_res;
    logic [15:0] echo_width;
  } stage_t;

  typedef struct packed {
    logic [7:0]  trigger_ticks;
    logic [15:0] timeout_ticks;
    logic [9:0]  sound_speed;
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/urc_fsm.sv
// Measurement state machine: trigger pulse, echo edge timing, timeout fault.
// Depends on urc_pkg. State advances once per accepted input transaction.
`default_nettype none

module urc_fsm #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire urc_pkg::in_t   item_i,
  input  wire urc_pkg::cfg_t  cfg_i,
  output urc_pkg::stage_t     stage_o
);

  localparam int unsigned CmpW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
  localparam longint unsigned TopVal =
    (COUNTER_BITS >= 16) ? 64'hFFFF : ((64'd1 << COUNTER_BITS) - 64'd1);
  localparam logic [COUNTER_BITS-1:0] CntTop = COUNTER_BITS'(TopVal);

  urc_pkg::phase_e           phase_q, phase_d;
  logic [COUNTER_BITS-1:0]   cnt_q, cnt_d;
  logic [15:0]               width_q, width_d;
  logic                      done_q, done_d;
  logic                      prev_q;

  logic [COUNTER_BITS-1:0]   cnt_sat;
  logic                      timed_out;
  logic                      rise, fall;

  // Saturating count and timeout check on the advanced count
  assign cnt_sat   = (cnt_q < CntTop) ? cnt_q + COUNTER_BITS'(1) : cnt_q;
  assign timed_out = (CmpW'(cnt_sat) >= CmpW'(cfg_i.timeout_ticks)) || (cnt_sat >= CntTop);
  assign rise      = item_i.echo_level & ~prev_q;
  assign fall      = ~item_i.echo_level & prev_q;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= urc_pkg::PH_IDLE;
      cnt_q   <= '0;
      width_q <= '0;
      done_q  <= 1'b0;
      prev_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      width_q <= width_d;
      done_q  <= done_d;
      prev_q  <= item_i.echo_level;
    end
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    width_d = width_q;
    done_d  = 1'b0;
    unique case (phase_q)
      urc_pkg::PH_IDLE, urc_pkg::PH_FAULT: begin
        if (item_i.start_req) begin
          phase_d = urc_pkg::PH_TRIG;
          cnt_d   = COUNTER_BITS'(1);
        end
      end
      urc_pkg::PH_TRIG: begin
        // a trigger length of zero ends after one tick, like one
        if (CmpW'(cnt_q) >= CmpW'(cfg_i.trigger_ticks)) begin
          phase_d = urc_pkg::PH_WAIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + COUNTER_BITS'(1);
        end
      end
      urc_pkg::PH_WAIT: begin
        if (rise) begin
          phase_d = urc_pkg::PH_HIGH;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_sat;
          if (timed_out) phase_d = urc_pkg::PH_FAULT;
        end
      end
      urc_pkg::PH_HIGH: begin
        cnt_d = cnt_sat;
        // falling edge wins over a timeout on the same tick
        if (fall) begin
          width_d = 16'(cnt_sat);
          phase_d = urc_pkg::PH_IDLE;
          done_d  = 1'b1;
        end else if (timed_out) begin
          phase_d = urc_pkg::PH_FAULT;
        end
      end
      default: begin
        phase_d = urc_pkg::PH_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // Result fields from the updated state
  always_comb begin
    stage_o.trigger_level = (phase_q == urc_pkg::PH_TRIG);
    stage_o.done_res      = done_q;
    stage_o.echo_width    = width_q;
    unique case (phase_q)
      urc_pkg::PH_TRIG:                   stage_o.status = urc_pkg::STATUS_TRIG;
      urc_pkg::PH_WAIT, urc_pkg::PH_HIGH: stage_o.status = urc_pkg::STATUS_MEASURE;
      urc_pkg::PH_FAULT:                  stage_o.status = urc_pkg::STATUS_FAULT;
      default:                            stage_o.status = urc_pkg::STATUS_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/urc_dist.sv
// Distance stages: (width >> 2) * speed, then divide by 1000 by reciprocal.
// Depends on urc_pkg. Two registered stages; the second drives the result channel.
`default_nettype none

module urc_dist (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s1_valid_i,
  input  wire urc_pkg::stage_t s1_i,
  input  wire logic [9:0]      speed_i,
  output logic                 s1_take_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output urc_pkg::out_t        out_data_o
);

  localparam int unsigned FullW = urc_pkg::PROD_W + urc_pkg::RECIP_W;

  logic                       v2_q, v3_q;
  logic                       adv2, adv3;
  urc_pkg::stage_t            s2_q;
  logic [urc_pkg::PROD_W-1:0] prod_q;
  urc_pkg::out_t              out_q;
  logic [FullW-1:0]           full;

  // Pipeline advance
  assign adv3      = ~v3_q | ~out_stall_i;
  assign adv2      = ~v2_q | adv3;
  assign s1_take_o = adv2;

  assign full = FullW'(prod_q) * FullW'(urc_pkg::RECIP_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv2) v2_q <= s1_valid_i;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Product stage
  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_q   <= s1_i;
      prod_q <= urc_pkg::PROD_W'(s1_i.echo_width[15:2]) * urc_pkg::PROD_W'(speed_i);
    end
  end

  // Reciprocal stage and result register
  always_ff @(posedge clk_i) begin
    if (adv3) begin
      out_q.trigger_level <= s2_q.trigger_level;
      out_q.status        <= s2_q.status;
      out_q.done_res      <= s2_q.done_res;
      out_q.echo_width    <= s2_q.echo_width;
      out_q.distance_mm   <= full[urc_pkg::RECIP_SHIFT +: 15];
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: sv/ultrasonic_ranger_controller_top.sv
// Top level of the ultrasonic ranger controller: config registers and pipeline glue.
// Depends on urc_pkg, urc_fsm and urc_dist.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------------
//   in      | in        | in_valid_i / in_stall_o   | urc_pkg::in_t (one tick)
//   out     | out       | out_valid_o / out_stall_i | urc_pkg::out_t
//   cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One transaction per clock sustained while the output is not stalled; each result
// passes the state register, which loads on the edge that accepts its input, then
// the multiply and reciprocal stage registers.
// Reset clears the state machine and loads default config; no clearing pass.
// An output stall backs up through the three stages; input is taken as long
// as any stage is free. Config writes are always ready.
`default_nettype none

module ultrasonic_ranger_controller_top #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire urc_pkg::in_t                     in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output urc_pkg::out_t                         out_data_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [urc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [urc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  urc_pkg::cfg_t   cfg_q;
  urc_pkg::stage_t s1;
  logic            v1_q;
  logic            s1_take;
  logic            accept;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks <= urc_pkg::TRIGGER_TICKS_RST;
      cfg_q.timeout_ticks <= urc_pkg::TIMEOUT_TICKS_RST;
      cfg_q.sound_speed   <= urc_pkg::SOUND_SPEED_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        urc_pkg::CFG_TRIGGER_TICKS: cfg_q.trigger_ticks <= cfg_data_i[7:0];
        urc_pkg::CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data_i[15:0];
        urc_pkg::CFG_SOUND_SPEED:   cfg_q.sound_speed   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Input side: state register doubles as first stage
  assign in_stall_o = v1_q & ~s1_take;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (accept) begin
      v1_q <= 1'b1;
    end else if (s1_take) begin
      v1_q <= 1'b0;
    end
  end

  urc_fsm #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .cfg_i    (cfg_q),
    .stage_o  (s1)
  );

  urc_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (v1_q),
    .s1_i        (s1),
    .speed_i     (cfg_q.sound_speed),
    .s1_take_o   (s1_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.done_res) |-> (out_data_o.status == urc_pkg::STATUS_IDLE))
    else $error("done pulse outside idle status");

  a_trig_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.trigger_level == (out_data_o.status == urc_pkg::STATUS_TRIG)))
    else $error("trigger level disagrees with status");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.distance_mm <= urc_pkg::DISTANCE_MAX))
    else $error("distance out of range");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !s1_take) |=> v1_q)
    else $error("first stage lost a transaction");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for ultrasonic_ranger_controller_top: echo timing, trigger,
// fault and distance per tick, checked against an in-bench predictor.
// Depends on urc_pkg and the RTL under sv/.
module tb_top;
  import urc_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;   // cycles without any transaction
  localparam int unsigned DRAIN_WAIT  = 4;      // pipeline latency plus margin
  localparam int unsigned HOLD_CYCLES = 120;    // long receiver hold-off
  localparam int unsigned SPEED_SCALE = 1000;   // m/s times ticks/4 down to mm
  localparam logic [15:0] COUNT_TOP   = 16'hFFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    in_t  item;
    logic typed;   // want holds a hand-written expectation
    out_t want;
  } tick_job_t;

  localparam in_t QUIET      = '{echo_level: 1'b0, start_req: 1'b0};
  localparam in_t START      = '{echo_level: 1'b0, start_req: 1'b1};
  localparam in_t ECHO       = '{echo_level: 1'b1, start_req: 1'b0};
  localparam in_t ECHO_START = '{echo_level: 1'b1, start_req: 1'b1};

  localparam out_t OUT_IDLE   = '{trigger_level: 1'b0, status: STATUS_IDLE, done_res: 1'b0,
                                  echo_width: 16'd0, distance_mm: 15'd0};
  localparam out_t OUT_TRIG   = '{trigger_level: 1'b1, status: STATUS_TRIG, done_res: 1'b0,
                                  echo_width: 16'd0, distance_mm: 15'd0};
  localparam out_t OUT_DONE3  = '{trigger_level: 1'b0, status: STATUS_IDLE, done_res: 1'b1,
                                  echo_width: 16'd3, distance_mm: 15'd0};
  localparam out_t OUT_FAULT3 = '{trigger_level: 1'b0, status: STATUS_FAULT, done_res: 1'b0,
                                  echo_width: 16'd3, distance_mm: 15'd0};
  localparam out_t OUT_DONE6  = '{trigger_level: 1'b0, status: STATUS_IDLE, done_res: 1'b1,
                                  echo_width: 16'd6, distance_mm: 15'd1};

  // Directed walk, run with trigger 2, timeout 6, speed 1023
  localparam tick_job_t DIRECTED_ROWS [28] = '{
    '{QUIET,      1'b1, OUT_IDLE},    // straight out of reset
    '{START,      1'b1, OUT_TRIG},    // trigger tick 1
    '{START,      1'b1, OUT_TRIG},    // start while triggering is ignored
    '{QUIET,      1'b0, '0},          // into waiting
    '{ECHO,       1'b0, '0},          // rising edge
    '{ECHO_START, 1'b0, '0},          // start while measuring is ignored
    '{ECHO,       1'b0, '0},
    '{QUIET,      1'b1, OUT_DONE3},   // falling edge captures 3
    '{ECHO_START, 1'b0, '0},          // start with echo already high
    '{ECHO,       1'b0, '0},
    '{ECHO,       1'b0, '0},          // waiting starts with echo high: no edge
    '{ECHO,       1'b0, '0},
    '{ECHO,       1'b0, '0},
    '{ECHO,       1'b0, '0},
    '{ECHO,       1'b0, '0},
    '{ECHO,       1'b0, '0},
    '{ECHO,       1'b1, OUT_FAULT3},  // count reaches timeout
    '{QUIET,      1'b1, OUT_FAULT3},  // fault holds
    '{START,      1'b0, '0},          // start accepted from fault
    '{QUIET,      1'b0, '0},
    '{QUIET,      1'b0, '0},
    '{ECHO,       1'b0, '0},
    '{ECHO,       1'b0, '0},
    '{ECHO,       1'b0, '0},
    '{ECHO,       1'b0, '0},
    '{ECHO,       1'b0, '0},
    '{ECHO,       1'b0, '0},
    '{QUIET,      1'b1, OUT_DONE6}    // fall on the timeout tick wins
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  ultrasonic_ranger_controller_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Ranger state and register copies kept by the predictor
  phase_e      rng_phase     = PH_IDLE;
  logic [15:0] rng_count     = '0;
  logic [15:0] rng_width     = '0;
  logic        rng_echo_prev = 1'b0;
  logic [7:0]  set_trigger   = TRIGGER_TICKS_RST;
  logic [15:0] set_timeout   = TIMEOUT_TICKS_RST;
  logic [9:0]  set_speed     = SOUND_SPEED_RST;

  tick_job_t   tick_q [$];
  out_t        due_results [$];
  int unsigned ticks_pending = 0;
  int unsigned ticks_pushed  = 0;
  int unsigned err_cnt       = 0;
  logic        calm          = 1'b1;   // no gaps and no stalls
  logic        hold_req      = 1'b0;

  // Advance the ranger by one tick and return the result it shows
  function automatic out_t ranger_tick(input in_t x);
    out_t        res;
    logic        done;
    int unsigned prod;
    done = 1'b0;
    case (rng_phase)
      PH_IDLE, PH_FAULT: begin
        if (x.start_req) begin
          rng_phase = PH_TRIG;
          rng_count = 16'd1;
        end
      end
      PH_TRIG: begin
        if (rng_count >= 16'(set_trigger)) begin
          rng_phase = PH_WAIT;
          rng_count = '0;
        end else begin
          rng_count++;
        end
      end
      PH_WAIT: begin
        if (x.echo_level && !rng_echo_prev) begin
          rng_phase = PH_HIGH;
          rng_count = '0;
        end else begin
          if (rng_count < COUNT_TOP) rng_count++;
          if (rng_count >= set_timeout || rng_count >= COUNT_TOP) rng_phase = PH_FAULT;
        end
      end
      PH_HIGH: begin
        if (rng_count < COUNT_TOP) rng_count++;
        if (!x.echo_level && rng_echo_prev) begin
          rng_width = rng_count;
          rng_phase = PH_IDLE;
          done      = 1'b1;
        end else if (rng_count >= set_timeout || rng_count >= COUNT_TOP) begin
          rng_phase = PH_FAULT;
        end
      end
      default: begin
        rng_phase = PH_IDLE;
        rng_count = '0;
      end
    endcase
    rng_echo_prev = x.echo_level;

    res.trigger_level = (rng_phase == PH_TRIG);
    case (rng_phase)
      PH_TRIG:          res.status = STATUS_TRIG;
      PH_WAIT, PH_HIGH: res.status = STATUS_MEASURE;
      PH_FAULT:         res.status = STATUS_FAULT;
      default:          res.status = STATUS_IDLE;
    endcase
    res.done_res    = done;
    res.echo_width  = rng_width;
    prod            = (32'(rng_width) >> 2) * 32'(set_speed);
    res.distance_mm = 15'(prod / SPEED_SCALE);
    return res;
  endfunction

  task automatic push_tick(input logic echo, input logic start);
    tick_q.push_back('{item: '{echo_level: echo, start_req: start}, typed: 1'b0, want: '0});
    ticks_pending++;
    ticks_pushed++;
  endtask

  task automatic wait_drained();
    while (ticks_pending != 0 || due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Register write, only once the ranger has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TRIGGER_TICKS: set_trigger = val[7:0];
      CFG_TIMEOUT_TICKS: set_timeout = val;
      CFG_SOUND_SPEED:   set_speed   = val[9:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly whole measurements with random timing, some noise in between
  task automatic run_measures(input int unsigned budget, input int unsigned trig,
                              input int unsigned tmo);
    int unsigned base, kind, trig_len, lead, width_ticks, cap;
    logic        stuck;
    base     = ticks_pushed;
    trig_len = (trig == 0) ? 1 : trig;
    cap      = (tmo + 3 < 400) ? tmo + 3 : 400;
    while (ticks_pushed - base < budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        repeat ($urandom_range(1, 20)) push_tick(1'($urandom), 1'($urandom));
      end else begin
        // echo held high through the trigger now and then
        stuck = (kind < 23);
        repeat ($urandom_range(0, 2)) push_tick(1'b0, 1'b0);
        push_tick(stuck, 1'b1);
        repeat (trig_len) push_tick(stuck, $urandom_range(0, 3) == 0);
        lead = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cap) : $urandom_range(0, 6);
        repeat (lead) push_tick(stuck, 1'b0);
        width_ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cap)
                                                  : $urandom_range(1, 30);
        repeat (width_ticks) push_tick(1'b1, $urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 3)) push_tick(1'b0, 1'b0);
      end
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (due_results.size() == 0) begin
      $error("result with nothing expected: %p", got);
      err_cnt++;
    end else begin
      want = due_results.pop_front();
      if (got.trigger_level !== want.trigger_level) begin
        $error("trigger_level: expected %0d, got %0d", want.trigger_level, got.trigger_level);
        err_cnt++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        err_cnt++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
        err_cnt++;
      end
      if (got.echo_width !== want.echo_width) begin
        $error("echo_width: expected %0d, got %0d", want.echo_width, got.echo_width);
        err_cnt++;
      end
      if (got.distance_mm !== want.distance_mm) begin
        $error("distance_mm: expected %0d, got %0d", want.distance_mm, got.distance_mm);
        err_cnt++;
      end
    end
  endtask

  // Input side: one tick per transaction, random gaps while not calm
  initial begin : tick_feeder
    tick_job_t   cur;
    out_t        pred;
    int unsigned gap_left;
    int unsigned r;
    cur      = '0;
    gap_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) begin
        pred = ranger_tick(cur.item);
        due_results.push_back(cur.typed ? cur.want : pred);
        ticks_pending--;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else if (tick_q.size() > 0) begin
          cur = tick_q.pop_front();
          in_data_i  <= cur.item;
          in_valid_i <= 1'b1;
          if (!calm) begin
            r = $urandom_range(0, 99);
            if (r >= 95) gap_left = $urandom_range(8, 30);
            else if (r >= 70) gap_left = $urandom_range(1, 3);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: check each transaction, stall at random while not calm or on a hold request
  always @(posedge clk_i) begin : result_sink
    int unsigned stall_left;
    int unsigned r;
    if (out_valid_o && !out_stall_i) check_result(out_data_o);
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (!calm) begin
        r = $urandom_range(0, 99);
        if (r >= 96) stall_left = $urandom_range(10, 40);
        else if (r >= 75) stall_left = $urandom_range(1, 3);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Test sequence
  initial begin : stimulus
    logic [7:0]  trig;
    logic [15:0] tmo;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk, starting from the reset state
    write_reg(CFG_TRIGGER_TICKS, 16'd2);
    write_reg(CFG_TIMEOUT_TICKS, 16'd6);
    write_reg(CFG_SOUND_SPEED, 16'd1023);
    calm = 1'b0;
    foreach (DIRECTED_ROWS[i]) begin
      tick_q.push_back(DIRECTED_ROWS[i]);
      ticks_pending++;
    end

    // reset register values, no idling
    write_reg(CFG_TRIGGER_TICKS, 16'(TRIGGER_TICKS_RST));
    write_reg(CFG_TIMEOUT_TICKS, TIMEOUT_TICKS_RST);
    write_reg(CFG_SOUND_SPEED, 16'(SOUND_SPEED_RST));
    calm = 1'b1;
    run_measures(60, TRIGGER_TICKS_RST, TIMEOUT_TICKS_RST);

    // zero trigger length, slowest sound, upper data bits set
    write_reg(CFG_TRIGGER_TICKS, {8'hA5, 8'd0});
    write_reg(CFG_TIMEOUT_TICKS, 16'd40);
    write_reg(CFG_SOUND_SPEED, {6'h3F, 10'd1});
    calm = 1'b0;
    run_measures(250, 0, 40);

    // longest trigger and timeout; receiver holds off to back up the pipe
    write_reg(CFG_TRIGGER_TICKS, {8'($urandom), 8'd255});
    write_reg(CFG_TIMEOUT_TICKS, 16'hFFFF);
    write_reg(CFG_SOUND_SPEED, {6'($urandom), 10'd343});
    hold_req = 1'b1;
    run_measures(540, 255, 16'hFFFF);

    // zero timeout, unused register index, no idling
    write_reg(CFG_SPARE, 16'($urandom));
    write_reg(CFG_TRIGGER_TICKS, 16'd1);
    write_reg(CFG_TIMEOUT_TICKS, 16'd0);
    write_reg(CFG_SOUND_SPEED, 16'd512);
    calm = 1'b1;
    run_measures(100, 1, 0);

    // random settings
    repeat (3) begin
      trig = 8'($urandom_range(0, 12));
      tmo  = 16'($urandom_range(1, 150));
      write_reg(CFG_TRIGGER_TICKS, {8'($urandom), trig});
      write_reg(CFG_TIMEOUT_TICKS, tmo);
      write_reg(CFG_SOUND_SPEED, 16'($urandom));
      calm = 1'b0;
      run_measures(200, trig, tmo);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/urc_pkg.sv
sv/urc_fsm.sv
sv/urc_dist.sv
sv/ultrasonic_ranger_controller_top.sv
tb/tb_top.sv
